>>> src/cptb_pkg.sv
// shared types and constants of the cascadable prescaled timer bank
package cptb_pkg;

    localparam int NUM_CFG_TIMERS = 4;
    localparam int CNT_W          = 16;
    localparam int PSC_W          = 10;
    localparam int DLY_W          = 2;
    localparam int CFG_IDX_W      = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_ZERO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_ONE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_TWO     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_THREE   = 3'd7;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // prescale divide ratios as shift amounts: 1, 64, 256, 1024
    localparam logic [3:0] PRESC_SHIFT [4] = '{4'd0, 4'd6, 4'd8, 4'd10};

    typedef struct packed {
        logic       irq_en;
        logic       cascade;
        logic [1:0] presc_sel;
    } t_mode;

    typedef struct packed {
        logic [CNT_W-1:0] reload;
        t_mode            mode;
    } t_tmr_cfg;

    typedef struct packed {
        logic start;
        logic stop;
        logic carry;
    } t_tmr_ctl;

endpackage

>>> src/cptb_cfg_regs.sv
// reload and mode registers behind the configuration write port
module cptb_cfg_regs
    import cptb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    output t_tmr_cfg             o_cfg [NUM_CFG_TIMERS]
);

    logic [CNT_W-1:0] r_reload [NUM_CFG_TIMERS];
    t_mode            r_mode   [NUM_CFG_TIMERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG_TIMERS; k++) begin
                r_reload[k] <= '0;
                r_mode[k]   <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RELOAD_ZERO:  r_reload[0] <= i_cfg_data;
                REG_RELOAD_ONE:   r_reload[1] <= i_cfg_data;
                REG_RELOAD_TWO:   r_reload[2] <= i_cfg_data;
                REG_RELOAD_THREE: r_reload[3] <= i_cfg_data;
                REG_MODE_ZERO:    r_mode[0]   <= t_mode'(i_cfg_data[3:0]);
                REG_MODE_ONE:     r_mode[1]   <= t_mode'(i_cfg_data[3:0]);
                REG_MODE_TWO:     r_mode[2]   <= t_mode'(i_cfg_data[3:0]);
                REG_MODE_THREE:   r_mode[3]   <= t_mode'(i_cfg_data[3:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_CFG_TIMERS; k++) begin
            o_cfg[k].reload = r_reload[k];
            o_cfg[k].mode   = r_mode[k];
        end
    end

endmodule

>>> src/cptb_timer.sv
// one reload timer: start/stop, start delay, prescaler, cascade and counter
module cptb_timer
    import cptb_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int START_DELAY = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  t_tmr_ctl         i_ctl,
    input  t_tmr_cfg         i_cfg,
    output logic [CNT_W-1:0] o_count,
    output logic             o_over
);

    localparam logic [DLY_W-1:0] DELAY_INIT = START_DELAY[DLY_W-1:0];
    // the lowest timer has nothing below it to cascade from
    localparam logic HAS_BELOW = (IDX > 0);

    logic             r_running, n_running;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [PSC_W-1:0] r_psc,     n_psc;
    logic [DLY_W-1:0] r_delay,   n_delay;
    logic             w_fresh;
    logic             w_tick;
    logic [PSC_W:0]   w_psc_inc;
    logic [PSC_W:0]   w_psc_lim;

    assign w_psc_inc = {1'b0, r_psc} + 1'b1;
    assign w_psc_lim = (PSC_W+1)'(1) << PRESC_SHIFT[i_cfg.mode.presc_sel];

    always_comb begin
        n_running = r_running;
        n_count   = r_count;
        n_psc     = r_psc;
        n_delay   = r_delay;
        w_fresh   = 1'b0;
        w_tick    = 1'b0;
        o_over    = 1'b0;

        // stop wins over start
        if (i_ctl.stop) begin
            n_running = 1'b0;
        end else if (i_ctl.start && !r_running) begin
            n_running = 1'b1;
            n_count   = i_cfg.reload;
            n_psc     = '0;
            n_delay   = i_cfg.mode.cascade ? '0 : DELAY_INIT;
            w_fresh   = 1'b1;
        end

        if (n_running && !w_fresh) begin
            if (i_cfg.mode.cascade) begin
                w_tick = HAS_BELOW && i_ctl.carry;
            end else if (r_delay != '0) begin
                n_delay = r_delay - 1'b1;
            end else if (w_psc_inc >= w_psc_lim) begin
                n_psc  = '0;
                w_tick = 1'b1;
            end else begin
                n_psc = w_psc_inc[PSC_W-1:0];
            end
        end

        if (w_tick) begin
            if (r_count == CNT_MAX) begin
                n_count = i_cfg.reload;
                o_over  = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_count   <= '0;
            r_psc     <= '0;
            r_delay   <= '0;
        end else if (i_advance) begin
            r_running <= n_running;
            r_count   <= n_count;
            r_psc     <= n_psc;
            r_delay   <= n_delay;
        end
    end

endmodule

>>> src/cascadable_prescaled_timer_bank.sv
// Bank of cascadable prescaled 16-bit reload timers.
//
// Each word on the input channel (i_in_valid / o_in_ready) is one timer tick
// carrying a start mask and a stop mask, one bit per timer. Each accepted
// word yields exactly one result word on the output channel (o_out_valid /
// i_out_ready): the four counter values after the tick, the mask of timers
// that overflowed and reloaded, and that mask gated by the irq enables.
// Reload values and modes go in through i_cfg_we / i_cfg_index / i_cfg_data,
// register i of the list at index i; the user must write them only while no
// tick is in flight, which the block itself does not enforce.
// A word is taken into an input register, the whole tick (start/stop, start
// delay, prescaler, cascade carry rippling through all timers) is worked out
// combinationally and lands in the result register. One word is accepted
// every cycle while the receiver does not stall. If the receiver stalls,
// the result register holds, the input register takes one more word, and
// o_in_ready then drops until the result is taken.
// Reset (synchronous, active low) stops all timers, clears counters,
// prescalers, delays and the config registers, and empties both stages.
module cascadable_prescaled_timer_bank
    import cptb_pkg::*;
#(
    parameter int NUM_TIMERS  = 4,
    parameter int START_DELAY = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [3:0]           i_start_mask,
    input  logic [3:0]           i_stop_mask,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CNT_W-1:0]     o_count_zero,
    output logic [CNT_W-1:0]     o_count_one,
    output logic [CNT_W-1:0]     o_count_two,
    output logic [CNT_W-1:0]     o_count_three,
    output logic [3:0]           o_overflow_mask,
    output logic [3:0]           o_irq_mask,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    logic       r_in_valid;
    logic [3:0] r_start;
    logic [3:0] r_stop;
    logic       w_advance;

    t_tmr_cfg   w_cfg [NUM_CFG_TIMERS];

    logic [CNT_W-1:0] w_count [NUM_TIMERS];
    logic             w_over  [NUM_TIMERS];

    logic [CNT_W-1:0] w_res_count [NUM_CFG_TIMERS];
    logic [3:0]       w_res_ovf;
    logic [3:0]       w_res_irq;

    logic             r_out_valid;
    logic [CNT_W-1:0] r_count [NUM_CFG_TIMERS];
    logic [3:0]       r_ovf;
    logic [3:0]       r_irq;

    // input stage moves on when the result register is empty or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_start <= i_start_mask;
            r_stop  <= i_stop_mask;
        end
    end

    cptb_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer
        t_tmr_ctl w_ctl;
        t_tmr_cfg w_tcfg;

        // timers above the register set have no mask bits and never start
        if (g < NUM_CFG_TIMERS) begin : g_ctl
            assign w_ctl.start = r_start[g];
            assign w_ctl.stop  = r_stop[g];
            assign w_tcfg      = w_cfg[g];
        end else begin : g_ctl
            assign w_ctl.start = 1'b0;
            assign w_ctl.stop  = 1'b0;
            assign w_tcfg      = '0;
        end

        if (g == 0) begin : g_carry
            assign w_ctl.carry = 1'b0;
        end else begin : g_carry
            assign w_ctl.carry = w_over[g-1];
        end

        cptb_timer #(
            .IDX         (g),
            .START_DELAY (START_DELAY)
        ) u_timer (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_ctl     (w_ctl),
            .i_cfg     (w_tcfg),
            .o_count   (w_count[g]),
            .o_over    (w_over[g])
        );
    end

    for (genvar k = 0; k < NUM_CFG_TIMERS; k++) begin : g_res
        if (k < NUM_TIMERS) begin : g_used
            assign w_res_count[k] = w_count[k];
            assign w_res_ovf[k]   = w_over[k];
        end else begin : g_used
            assign w_res_count[k] = '0;
            assign w_res_ovf[k]   = 1'b0;
        end
        assign w_res_irq[k] = w_res_ovf[k] && w_cfg[k].mode.irq_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            for (int k = 0; k < NUM_CFG_TIMERS; k++) begin
                r_count[k] <= w_res_count[k];
            end
            r_ovf <= w_res_ovf;
            r_irq <= w_res_irq;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_count_zero    = r_count[0];
    assign o_count_one     = r_count[1];
    assign o_count_two     = r_count[2];
    assign o_count_three   = r_count[3];
    assign o_overflow_mask = r_ovf;
    assign o_irq_mask      = r_irq;

endmodule

>>> src/cptb_checker.sv
// port-level checks of the timer bank, bound to the top level
module cptb_checker
    import cptb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [CNT_W-1:0] i_count_zero,
    input logic [3:0]       i_overflow_mask,
    input logic [3:0]       i_irq_mask
);

    // an irq bit only ever accompanies an overflow of the same timer
    a_irq_in_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_irq_mask & ~i_overflow_mask) == 4'd0))
        else $error("irq bit without overflow");

    // input side only backs up when the result is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input not ready without output stall");

    // a fresh result comes from an accepted word that passed through the input register
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without an accepted word");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_count_zero) && $stable(i_overflow_mask)))
        else $error("stalled result changed");

endmodule

bind cascadable_prescaled_timer_bank cptb_checker u_cptb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .i_in_ready      (o_in_ready),
    .i_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .i_count_zero    (o_count_zero),
    .i_overflow_mask (o_overflow_mask),
    .i_irq_mask      (o_irq_mask)
);
